FILE: src/srf_pkg.sv
`timescale 1ns / 1ps
package srf_pkg;

   localparam logic [7:0]  CH_DASH    = 8'h2D;
   localparam logic [7:0]  CH_SPACE   = 8'h20;
   localparam logic [7:0]  CH_CR      = 8'h0D;
   localparam logic [7:0]  CH_LF      = 8'h0A;
   localparam logic [23:0] CODE_220   = 24'h323230;
   localparam logic [23:0] CODE_250   = 24'h323530;
   localparam int          CODE_BYTES = 3;

   localparam int          CSR_AW     = 4;
   localparam int          CSR_DW     = 32;

   typedef enum logic [1:0] {
      REG_USE_FIXED = 2'd0,
      REG_EXP_CODE  = 2'd1,
      REG_MAX_LEN   = 2'd2,
      REG_NONE      = 2'd3
   } reg_idx_type;

   typedef enum logic [1:0] {
      ST_MORE = 2'd0,
      ST_DONE = 2'd1,
      ST_ERR  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      PH_CODE0 = 3'd0,
      PH_CODE1 = 3'd1,
      PH_CODE2 = 3'd2,
      PH_SEP   = 3'd3,
      PH_TEXT  = 3'd4
   } phase_type;

   typedef struct packed {
      logic        use_fixed_code;
      logic [23:0] expected_code;
      logic [15:0] max_length;
   } cfg_type;

   // byte idx of a packed three-byte code, first byte in the top bits
   function automatic logic [7:0] code_byte(input logic [23:0] code, input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = code[23:16];
         2'd1:    b = code[15:8];
         default: b = code[7:0];
      endcase
      return b;
   endfunction

endpackage

FILE: src/srf_req_if.sv
`timescale 1ns / 1ps
interface srf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: src/srf_rsp_if.sv
`timescale 1ns / 1ps
interface srf_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  frame_status;
   logic [15:0] reply_length;

   modport source (output valid, output frame_status, output reply_length, input ready);
   modport sink (input valid, input frame_status, input reply_length, output ready);
endinterface

FILE: src/smtp_reply_framer.sv
`timescale 1ns / 1ps
// SMTP multi-line reply framer, one received byte per transfer.
// The status for a byte is registered and presented on rsp in the cycle after its req transfer.
// Throughput: one byte per cycle; req stays ready while the result register
// is empty or being drained in the same cycle.
// Reset (synchronous, active high) clears framing state and the result valid,
// and loads registers with fixed-code off, expected code "250", max length 65535.
module smtp_reply_framer (
   input  logic                       clock,
   input  logic                       reset,
   srf_req_if.sink                    req_chan,
   srf_rsp_if.source                  rsp_chan,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [srf_pkg::CSR_AW-1:0] paddr,
   input  logic [srf_pkg::CSR_DW-1:0] pwdata,
   output logic [srf_pkg::CSR_DW-1:0] prdata,
   output logic                       pready
);
   import srf_pkg::*;

   cfg_type     cfg;
   status_type  status;
   logic [15:0] length;
   logic        req_xfer;

   logic        rsp_valid_ff, rsp_valid_in;
   status_type  rsp_status_ff;
   logic [15:0] rsp_length_ff;

   // Register block: use_fixed_code at 0x0, expected_code at 0x4, max_length at 0x8.
   srf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Accept whenever the result register frees up this cycle; the result
   // register is the only thing between the two sides.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   // Framing state advances only on a req transfer; status is combinational
   // off the current state and the incoming byte.
   srf_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step    (req_xfer),
      .rx_byte (req_chan.rx_byte),
      .status  (status),
      .length  (length)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_status_ff <= status;
         rsp_length_ff <= length;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.frame_status = rsp_status_ff;
   assign rsp_chan.reply_length = rsp_length_ff;
endmodule

FILE: src/srf_csr.sv
`timescale 1ns / 1ps
module srf_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [srf_pkg::CSR_AW-1:0]  paddr,
   input  logic [srf_pkg::CSR_DW-1:0]  pwdata,
   output logic [srf_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready,
   output srf_pkg::cfg_type            cfg
);
   import srf_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type idx;
   logic        wr_en;

   assign idx    = reg_idx_type'(paddr[CSR_AW-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_USE_FIXED: cfg_in.use_fixed_code = pwdata[0];
            REG_EXP_CODE:  cfg_in.expected_code  = pwdata[23:0];
            REG_MAX_LEN:   cfg_in.max_length     = pwdata[15:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_USE_FIXED: prdata = {31'd0, cfg_ff.use_fixed_code};
         REG_EXP_CODE:  prdata = {8'd0, cfg_ff.expected_code};
         REG_MAX_LEN:   prdata = {16'd0, cfg_ff.max_length};
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.use_fixed_code <= 1'b0;
         cfg_ff.expected_code  <= CODE_250;
         cfg_ff.max_length     <= 16'hFFFF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

FILE: src/srf_core.sv
`timescale 1ns / 1ps
module srf_core (
   input  logic                clock,
   input  logic                reset,
   input  srf_pkg::cfg_type    cfg,
   input  logic                step,
   input  logic [7:0]          rx_byte,
   output srf_pkg::status_type status,
   output logic [15:0]         length
);
   import srf_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [23:0] learned_ff, learned_in;
   logic        known_ff, known_in;
   logic        last_ff, last_in;
   logic        prev_cr_ff, prev_cr_in;
   logic [15:0] count_ff, count_in;

   logic [16:0] count_next;
   logic        over;
   logic        is_code;
   logic [1:0]  code_idx;
   logic        code_bad;
   logic        crlf;

   assign count_next = {1'b0, count_ff} + 17'd1;
   assign over       = count_next > {1'b0, cfg.max_length};
   assign crlf       = prev_cr_ff && (rx_byte == CH_LF);

   // phases past text are treated as code byte zero
   always_comb begin
      case (phase_ff)
         PH_CODE1: begin is_code = 1'b1; code_idx = 2'd1; end
         PH_CODE2: begin is_code = 1'b1; code_idx = 2'd2; end
         PH_SEP:   begin is_code = 1'b0; code_idx = 2'd0; end
         PH_TEXT:  begin is_code = 1'b0; code_idx = 2'd0; end
         default:  begin is_code = 1'b1; code_idx = 2'd0; end
      endcase
   end

   always_comb begin
      if (cfg.use_fixed_code) begin
         code_bad = rx_byte != code_byte(cfg.expected_code, code_idx);
      end else if (known_ff) begin
         code_bad = rx_byte != code_byte(learned_ff, code_idx);
      end else begin
         code_bad = 1'b0;
      end
   end

   // status for this byte
   always_comb begin
      status = ST_MORE;
      length = '0;
      if (over) begin
         status = ST_ERR;
      end else if (is_code) begin
         if (code_bad) status = ST_ERR;
      end else if (phase_ff == PH_SEP) begin
         if (rx_byte != CH_DASH && rx_byte != CH_SPACE && rx_byte != CH_CR) status = ST_ERR;
      end else if (crlf && last_ff) begin
         status = ST_DONE;
         length = count_next[15:0];
      end
   end

   // next state
   always_comb begin
      phase_in   = phase_ff;
      learned_in = learned_ff;
      known_in   = known_ff;
      last_in    = last_ff;
      prev_cr_in = prev_cr_ff;
      count_in   = count_ff;
      if (step) begin
         if (status != ST_MORE) begin
            phase_in   = PH_CODE0;
            learned_in = '0;
            known_in   = 1'b0;
            last_in    = 1'b0;
            prev_cr_in = 1'b0;
            count_in   = '0;
         end else begin
            count_in = count_next[15:0];
            if (is_code) begin
               if (!cfg.use_fixed_code && !known_ff) begin
                  case (code_idx)
                     2'd0:    learned_in[23:16] = learned_ff[23:16] | rx_byte;
                     2'd1:    learned_in[15:8]  = learned_ff[15:8] | rx_byte;
                     default: learned_in[7:0]   = learned_ff[7:0] | rx_byte;
                  endcase
               end
               case (code_idx)
                  2'd0:    phase_in = PH_CODE1;
                  2'd1:    phase_in = PH_CODE2;
                  default: begin
                     phase_in = PH_SEP;
                     known_in = 1'b1;
                  end
               endcase
            end else if (phase_ff == PH_SEP) begin
               phase_in   = PH_TEXT;
               last_in    = rx_byte != CH_DASH;
               prev_cr_in = rx_byte == CH_CR;
            end else if (crlf) begin
               // end of a continuation line
               phase_in   = PH_CODE0;
               prev_cr_in = 1'b0;
            end else begin
               prev_cr_in = rx_byte == CH_CR;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_CODE0;
         learned_ff <= '0;
         known_ff   <= 1'b0;
         last_ff    <= 1'b0;
         prev_cr_ff <= 1'b0;
         count_ff   <= '0;
      end else begin
         phase_ff   <= phase_in;
         learned_ff <= learned_in;
         known_ff   <= known_in;
         last_ff    <= last_in;
         prev_cr_ff <= prev_cr_in;
         count_ff   <= count_in;
      end
   end
endmodule

FILE: bench/srf_reply_checker.sv
`timescale 1ns / 1ps
// Watches req, rsp and the register port; predicts the status of every byte
// and compares each rsp transfer with the oldest status still due.
module srf_reply_checker (
   input  logic                       clock,
   input  logic                       reset,
   srf_req_if                         req_mon,
   srf_rsp_if                         rsp_mon,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [srf_pkg::CSR_AW-1:0] paddr,
   input  logic [srf_pkg::CSR_DW-1:0] pwdata,
   input  logic                       pready,
   output int                         fail_count,
   output int                         pending
);
   import srf_pkg::*;

   typedef struct {
      status_type  status;
      logic [15:0] length;
   } byte_status_type;

   byte_status_type status_due_q[$];
   int              results_seen;

   // register copy
   logic        fixed_mode;
   logic [23:0] match_code;
   logic [15:0] length_limit;

   // framing state
   phase_type   phase;
   logic [23:0] learned;
   logic        code_seen;
   logic        final_line;
   logic        saw_cr;
   logic [15:0] reply_bytes;

   initial begin
      fail_count   = 0;
      pending      = 0;
      results_seen = 0;
   end

   task automatic restart_reply();
      phase       = PH_CODE0;
      learned     = '0;
      code_seen   = 1'b0;
      final_line  = 1'b0;
      saw_cr      = 1'b0;
      reply_bytes = '0;
   endtask

   task automatic report_mismatch(input string what, input int got_v, input int want_v);
      fail_count++;
      $display("%0t: result %0d, %s: got %0d, expected %0d",
               $time, results_seen, what, got_v, want_v);
   endtask

   task automatic frame_next_byte(input logic [7:0] b, output byte_status_type res);
      logic [16:0] count;
      logic [23:0] ref_code;
      int          idx;
      count      = {1'b0, reply_bytes} + 17'd1;
      res.status = ST_MORE;
      res.length = '0;
      // length limit wins over everything else
      if (count > {1'b0, length_limit}) begin
         res.status = ST_ERR;
      end else begin
         reply_bytes = count[15:0];
         if (phase < PH_SEP) begin
            idx      = int'(phase);
            ref_code = fixed_mode ? match_code : learned;
            if (fixed_mode || code_seen) begin
               if (b != ref_code[(2 - idx) * 8 +: 8]) begin
                  res.status = ST_ERR;
               end
            end else begin
               learned = learned | (24'(b) << ((2 - idx) * 8));
            end
            if (res.status == ST_MORE) begin
               if (idx == CODE_BYTES - 1) begin
                  code_seen = 1'b1;
               end
               phase = phase_type'(idx + 1);
            end
         end else if (phase == PH_SEP) begin
            case (b)
               CH_DASH: begin
                  final_line = 1'b0;
                  saw_cr     = 1'b0;
                  phase      = PH_TEXT;
               end
               CH_SPACE: begin
                  final_line = 1'b1;
                  saw_cr     = 1'b0;
                  phase      = PH_TEXT;
               end
               CH_CR: begin
                  // this CR may close the line right away
                  final_line = 1'b1;
                  saw_cr     = 1'b1;
                  phase      = PH_TEXT;
               end
               default: begin
                  res.status = ST_ERR;
               end
            endcase
         end else begin
            if (saw_cr && b == CH_LF) begin
               if (final_line) begin
                  res.status = ST_DONE;
                  res.length = reply_bytes;
               end else begin
                  phase  = PH_CODE0;
                  saw_cr = 1'b0;
               end
            end else begin
               saw_cr = (b == CH_CR);
            end
         end
      end
      if (res.status != ST_MORE) begin
         restart_reply();
      end
   endtask

   // Inputs and outputs only move at the rising edge, so what is seen at the
   // falling edge is what the next rising edge will act on.
   always @(negedge clock) begin : monitor
      byte_status_type want;
      if (reset) begin
         restart_reply();
         fixed_mode   = 1'b0;
         match_code   = CODE_250;
         length_limit = 16'hFFFF;
         status_due_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            results_seen++;
            if (status_due_q.size() == 0) begin
               report_mismatch("result with none due", rsp_mon.frame_status, -1);
            end else begin
               want = status_due_q.pop_front();
               if (rsp_mon.frame_status !== want.status) begin
                  report_mismatch("frame_status", rsp_mon.frame_status, want.status);
               end
               if (rsp_mon.reply_length !== want.length) begin
                  report_mismatch("reply_length", rsp_mon.reply_length, want.length);
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            frame_next_byte(req_mon.rx_byte, want);
            status_due_q.push_back(want);
         end
         if (psel && penable && pwrite && pready) begin
            case (reg_idx_type'(paddr[CSR_AW-1:2]))
               REG_USE_FIXED: fixed_mode   = pwdata[0];
               REG_EXP_CODE:  match_code   = pwdata[23:0];
               REG_MAX_LEN:   length_limit = pwdata[15:0];
               default: ;
            endcase
         end
      end
      pending = status_due_q.size();
   end

endmodule

FILE: bench/tb_smtp_reply_framer.sv
`timescale 1ns / 1ps
// Testbench top for the SMTP reply framer.
// Feeds directed replies (bare CR line, lone CR in text, code mismatch on a
// later line, bad separator, length limit hit exactly and by one), then
// random phases of mostly well-formed multi-line replies with corruption and
// noise mixed in. Each phase runs under a fresh register setting; phases end
// mid-reply on purpose so register writes land inside a reply.
// Checking lives in srf_reply_checker; this module only drives and judges.
module tb_smtp_reply_framer;
   import srf_pkg::*;

   localparam int RANDOM_ITEMS = 400;
   localparam int HOLD_CYCLES  = 60;    // long receiver hold-off
   localparam int IDLE_LIMIT   = 1000;  // cycles without any transfer

   logic              clock   = 1'b0;
   logic              reset   = 1'b1;
   logic              psel    = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite  = 1'b0;
   logic [CSR_AW-1:0] paddr   = '0;
   logic [CSR_DW-1:0] pwdata  = '0;
   logic [CSR_DW-1:0] prdata;
   logic              pready;

   srf_req_if req_chan ();
   srf_rsp_if rsp_chan ();

   int          fail_count;
   int          pending;
   int          idle_cycles = 0;
   int          sent = 0;
   bit          send_gaps = 1'b0;     // sender idles at random
   bit          stall_on = 1'b0;      // receiver stalls at random
   bit          hold_request = 1'b0;  // receiver holds off for HOLD_CYCLES
   logic [7:0]  reply_q[$];           // bytes of the reply being sent
   logic        cur_fixed;
   logic [23:0] cur_code;

   always #5 clock = ~clock;

   smtp_reply_framer u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   srf_reply_checker u_chk (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .pready     (pready),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Mostly short gaps, now and then a long one.
   function automatic int idle_gap();
      if ($urandom_range(0, 15) == 0) begin
         return $urandom_range(12, 40);
      end
      return $urandom_range(1, 3);
   endfunction

   // Watchdog: any transfer on any port restarts the count.
   always @(negedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (psel && penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver. Ready goes low for a random gap, or for the long hold when
   // the stimulus asks; otherwise it stays high for one cycle per pass.
   initial begin
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (stall_on && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (idle_gap()) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // Register write: setup cycle, then access until pready.
   task automatic csr_write(input reg_idx_type idx, input logic [CSR_DW-1:0] data);
      bit done;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do begin
         @(negedge clock);
         done = pready;
         @(posedge clock);
      end while (!done);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // One byte transfer on req. Valid is lowered only when a gap is taken, so
   // back-to-back bytes keep it high with a single assignment per edge.
   task automatic send_byte(input logic [7:0] b);
      bit taken;
      if (send_gaps && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat (idle_gap()) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= b;
      do begin
         @(negedge clock);
         taken = req_chan.ready;
         @(posedge clock);
      end while (!taken);
      sent++;
   endtask

   task automatic send_reply();
      foreach (reply_q[i]) send_byte(reply_q[i]);
   endtask

   // Wait until every status is back; the framer keeps each status in its single result
   // register and every byte yields a status, so a short pause after that leaves it idle.
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Well-formed reply: 1..4 lines, '-' on all but the last, the last with
   // ' ' or a bare CR; text may hold lone CRs but never LF.
   task automatic make_reply(input logic [23:0] code);
      int         lines;
      logic [7:0] sep;
      logic [7:0] t;
      reply_q.delete();
      lines = $urandom_range(1, 4);
      for (int l = 0; l < lines; l++) begin
         reply_q.push_back(code[23:16]);
         reply_q.push_back(code[15:8]);
         reply_q.push_back(code[7:0]);
         if (l < lines - 1) begin
            sep = CH_DASH;
         end else begin
            sep = ($urandom_range(0, 1) != 0) ? CH_SPACE : CH_CR;
         end
         reply_q.push_back(sep);
         if (sep == CH_CR && $urandom_range(0, 2) != 0) begin
            // separator CR doubles as the CR of the line end
            reply_q.push_back(CH_LF);
         end else begin
            repeat ($urandom_range(0, 6)) begin
               t = ($urandom_range(0, 7) == 0) ? CH_CR : 8'($urandom_range(0, 255));
               if (t == CH_LF) begin
                  t = 8'h7E;
               end
               reply_q.push_back(t);
            end
            reply_q.push_back(CH_CR);
            reply_q.push_back(CH_LF);
         end
      end
      // some replies get one byte overwritten
      if ($urandom_range(0, 7) == 0) begin
         reply_q[$urandom_range(0, reply_q.size() - 1)] = 8'($urandom_range(0, 255));
      end
   endtask

   initial begin : stimulus
      int          phase;
      int          total;
      int          target;
      int          keep;
      logic [23:0] code;
      logic [15:0] max_len;

      req_chan.valid   = 1'b0;
      req_chan.rx_byte = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, reset registers: free mode, no practical length limit.
      // Bare last line closed by the separator CR.
      reply_q = '{"2", "2", "0", CH_CR, CH_LF};
      send_reply();
      // Extreme code bytes, lone CR in text, then a later line whose code
      // differs from the learned one in its second byte.
      reply_q = '{8'hFF, 8'h00, "1", CH_DASH, CH_CR, 8'hFF, CH_CR, CH_LF, 8'hFF, 8'h01};
      send_reply();
      // Bad separator.
      reply_q = '{"2", "5", "0", "X"};
      send_reply();
      drain();

      // Fixed code "220", max length 5; the unmapped index must be ignored.
      csr_write(REG_USE_FIXED, {31'($urandom), 1'b1});
      csr_write(REG_EXP_CODE, {8'($urandom), CODE_220});
      csr_write(REG_MAX_LEN, {16'($urandom), 16'd5});
      csr_write(REG_NONE, $urandom);
      cur_fixed = 1'b1;
      cur_code  = CODE_220;
      // exactly the limit completes; one byte more is an error
      reply_q = '{"2", "2", "0", CH_CR, CH_LF, "2", "2", "0", " ", "a", CH_CR};
      send_reply();
      drain();

      // Random phases, each under its own register setting.
      total = sent + RANDOM_ITEMS;
      phase = 0;
      while (sent < total) begin
         if (phase == 0) begin
            // all-ones code in fixed mode
            cur_fixed = 1'b1;
            cur_code  = 24'hFFFFFF;
            max_len   = 16'hFFFF;
         end else if (phase == 1) begin
            // zero length limit: every byte is an error
            cur_fixed = 1'b0;
            cur_code  = 24'h000000;
            max_len   = 16'd0;
         end else begin
            cur_fixed = ($urandom_range(0, 1) != 0);
            cur_code  = ($urandom_range(0, 3) == 0) ? 24'($urandom)
                        : {8'h32, 8'h30 + 8'($urandom_range(0, 9)), 8'h30};
            case ($urandom_range(0, 3))
               0:       max_len = 16'hFFFF;
               1:       max_len = 16'($urandom_range(5, 12));
               2:       max_len = 16'($urandom_range(13, 60));
               default: max_len = 16'($urandom);
            endcase
         end
         csr_write(REG_USE_FIXED, {31'($urandom), cur_fixed});
         csr_write(REG_EXP_CODE, {8'($urandom), cur_code});
         csr_write(REG_MAX_LEN, {16'($urandom), max_len});
         if ($urandom_range(0, 3) == 0) begin
            csr_write(REG_NONE, $urandom);
         end

         send_gaps = ($urandom_range(0, 2) != 0);
         stall_on  = ($urandom_range(0, 2) != 0);
         if (phase == 3) begin
            // back-pressure: receiver holds off while bytes keep coming
            send_gaps    = 1'b0;
            hold_request = 1'b1;
         end

         target = sent + ((phase == 1) ? 12 : $urandom_range(30, 70));
         while (sent < target) begin
            if ($urandom_range(0, 9) == 0) begin
               // noise bytes
               reply_q.delete();
               repeat ($urandom_range(1, 5)) reply_q.push_back(8'($urandom_range(0, 255)));
            end else begin
               if (cur_fixed) begin
                  code = cur_code;
               end else if ($urandom_range(0, 3) == 0) begin
                  code = 24'($urandom);
               end else begin
                  code = {8'h30 + 8'($urandom_range(1, 5)), 8'h30 + 8'($urandom_range(0, 9)),
                          8'h30 + 8'($urandom_range(0, 9))};
               end
               make_reply(code);
            end
            send_reply();
         end

         // leave the framer mid-reply before the next register writes
         make_reply(cur_code);
         keep = $urandom_range(0, reply_q.size() - 1);
         while (reply_q.size() > keep) void'(reply_q.pop_back());
         send_reply();
         drain();
         phase++;
      end

      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: files.f
src/srf_pkg.sv
src/srf_req_if.sv
src/srf_rsp_if.sv
src/srf_csr.sv
src/srf_core.sv
src/smtp_reply_framer.sv
bench/srf_reply_checker.sv
bench/tb_smtp_reply_framer.sv
